>>> hw/rtl/tsi_pkg.sv
// Shared types and constants for the timestamped sample interpolator.
// No dependencies.
package tsi_pkg;

  localparam logic CmdPush    = 1'b0;
  localparam logic CmdAdvance = 1'b1;

  localparam logic [1:0] RegDelay    = 2'd0;
  localparam logic [1:0] RegCapacity = 2'd1;
  localparam logic [1:0] RegTickRate = 2'd2;

  localparam logic [31:0] DelayReset    = 32'd3;
  localparam logic [6:0]  CapacityReset = 7'd64;
  localparam logic [9:0]  TickRateReset = 10'd30;

  // one queued item between front and back
  typedef struct packed {
    logic        cmd;
    logic [31:0] point_tick;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] elapsed;
  } item_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [47:0] out_x;
    logic signed [47:0] out_y;
    logic               push_accepted;
    logic [6:0]         point_count;
  } result_t;

endpackage

>>> hw/rtl/timestamped_sample_interpolator.sv
// Top level: config registers, front queue and back part.
// Depends on tsi_pkg, tsi_front, tsi_back.
//
//  channel | valid        | ready        | payload
//  in      | in_valid_i   | in_ready_o   | cmd_i point_tick_i pos_x_i pos_y_i elapsed_i
//  out     | out_valid_o  | out_ready_i  | valid_res_o out_x_o out_y_o push_accepted_o
//          |              |              | point_count_o
//  cfg     | cfg_valid_i  | cfg_ready_o  | cfg_index_i cfg_data_i
//
// An item passes through the front queue, then the setup states for a push or an
// advance, the walk over the ring slots (up to 64), and either a copy of an end
// point or a divide and blend (17 quotient bits, one per cycle). One item in the
// back part at a time; two wait in front, and a finished result waits in an output
// register while the back part takes the next.
// Reset clears control state; the point memories hold garbage until written.
module timestamped_sample_interpolator #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [31:0]        point_tick_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] elapsed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               valid_res_o,
  output logic signed [47:0] out_x_o,
  output logic signed [47:0] out_y_o,
  output logic               push_accepted_o,
  output logic [6:0]         point_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [31:0] delay_q;
  logic [6:0]  cap_q;
  logic [9:0]  rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= tsi_pkg::DelayReset;
      cap_q   <= tsi_pkg::CapacityReset;
      rate_q  <= tsi_pkg::TickRateReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tsi_pkg::RegDelay:    delay_q <= cfg_data_i;
        tsi_pkg::RegCapacity: cap_q   <= cfg_data_i[6:0];
        tsi_pkg::RegTickRate: rate_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  tsi_pkg::item_t   in_item, q_item;
  tsi_pkg::result_t res;
  logic q_valid, q_ready;

  assign in_item = '{cmd: cmd_i, point_tick: point_tick_i, pos_x: pos_x_i,
                     pos_y: pos_y_i, elapsed: elapsed_i};

  tsi_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  tsi_back #(.DEPTH(DEPTH)) u_back (
    .clk_i, .rst_ni, .item_valid_i(q_valid), .item_ready_o(q_ready), .item_i(q_item),
    .delay_ticks_i(delay_q), .capacity_i(cap_q), .tick_rate_i(rate_q),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign valid_res_o     = res.valid_res;
  assign out_x_o         = res.out_x;
  assign out_y_o         = res.out_y;
  assign push_accepted_o = res.push_accepted;
  assign point_count_o   = res.point_count;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(point_count_o) <= DEPTH)) else $error("count over depth");
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valid_res_o == (point_count_o != 7'd0))) else $error("valid mismatch");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (out_x_o == 48'sd0 && out_y_o == 48'sd0))
    else $error("empty output not zero");

endmodule

>>> hw/rtl/tsi_front.sv
// Front part: two-entry queue that takes items and holds them for the back part.
// Depends on tsi_pkg.
module tsi_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tsi_pkg::item_t in_item_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output tsi_pkg::item_t q_item_o
);

  tsi_pkg::item_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hw/rtl/tsi_back.sv
// Back part: point ring memory, render tick update, segment search and blend.
// Depends on tsi_pkg.
module tsi_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  tsi_pkg::item_t  item_i,
  input  logic [31:0]     delay_ticks_i,
  input  logic [6:0]      capacity_i,
  input  logic [9:0]      tick_rate_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output tsi_pkg::result_t res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RDL   = 5'd1;  // read newest tick
  localparam logic [4:0] S_PUSH  = 5'd2;
  localparam logic [4:0] S_RDF   = 5'd3;  // read oldest tick
  localparam logic [4:0] S_ADV   = 5'd4;
  localparam logic [4:0] S_ADV2  = 5'd5;
  localparam logic [4:0] S_SRD   = 5'd6;  // search read
  localparam logic [4:0] S_SCMP  = 5'd7;
  localparam logic [4:0] S_DIV   = 5'd8;
  localparam logic [4:0] S_XWT   = 5'd10;
  localparam logic [4:0] S_MUL   = 5'd11;
  localparam logic [4:0] S_SUM   = 5'd12;
  localparam logic [4:0] S_OUT   = 5'd13;
  localparam logic [4:0] S_RDF2  = 5'd14;
  localparam logic [4:0] S_RDL2  = 5'd15;
  localparam logic [4:0] S_ADV0  = 5'd16;

  logic [31:0] tick_mem [DEPTH];
  logic [31:0] x_mem [DEPTH];
  logic [31:0] y_mem [DEPTH];

  logic [4:0]    st_q, st_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d;
  logic [47:0]   render_q, render_d;
  logic          started_q, started_d;
  logic          acc_q, acc_d;
  tsi_pkg::item_t it_q, it_d;

  logic [AW-1:0] raddr_q, raddr_d;
  logic [31:0]   trd_q, xrd_q, yrd_q;
  logic          we;
  logic [AW-1:0] waddr;

  logic [31:0]   first_q, first_d, latest_q, latest_d;
  logic [48:0]   sum_q, sum_d;
  logic [CW-1:0] k_q, k_d;
  logic [31:0]   pt_q, pt_d, nt_q, nt_d;
  logic [31:0]   ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [48:0]   rem_q, rem_d;
  logic [16:0]   quo_q, quo_d;
  logic [5:0]    dbit_q, dbit_d;
  logic signed [49:0] px_q, px_d, py_q, py_d;
  logic          sel_q, sel_d;  // 0 blend, 1 copy a
  tsi_pkg::result_t res_q, res_d;
  logic          rv_q, rv_d;

  logic [CW-1:0] cap;
  logic [6:0]    capc;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
    logic [CW:0] s;
    begin
      s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, k};
      if (s >= (CW + 1)'(DEPTH)) s = s - (CW + 1)'(DEPTH);
      return s[AW-1:0];
    end
  endfunction

  always_comb begin
    capc = capacity_i;
    if (capc < 7'd2) capc = 7'd2;
    if ({25'd0, capc} > 32'(DEPTH)) cap = CW'(DEPTH);
    else cap = CW'(capc);
  end

  assign item_ready_o = (st_q == S_IDLE);
  assign res_valid_o  = rv_q;
  assign res_o        = res_q;
  assign we    = (st_q == S_PUSH) &&
                 ((count_q == '0) || (it_q.point_tick > trd_q));
  // a full ring writes over the oldest slot
  assign waddr = slot(oldest_q, count_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      tick_mem[waddr] <= it_q.point_tick;
      x_mem[waddr]    <= it_q.pos_x;
      y_mem[waddr]    <= it_q.pos_y;
    end
    trd_q <= tick_mem[raddr_d];
    xrd_q <= x_mem[raddr_d];
    yrd_q <= y_mem[raddr_d];
  end

  // restoring division, 17 quotient bits, one bit a cycle
  logic [49:0] trial;
  logic [31:0] span;
  logic [47:0] pt_sh;
  logic [47:0] num;
  assign span  = nt_q - pt_q;
  assign pt_sh = {pt_q, 16'd0};
  assign num   = render_q - pt_sh;
  assign trial = {1'b0, rem_q[47:0], num[dbit_q]} - {18'd0, span};

  always_comb begin
    st_d = st_q; oldest_d = oldest_q; count_d = count_q; render_d = render_q;
    started_d = started_q; acc_d = acc_q; it_d = it_q; raddr_d = raddr_q;
    first_d = first_q; latest_d = latest_q; sum_d = sum_q; k_d = k_q;
    pt_d = pt_q; nt_d = nt_q; ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    rem_d = rem_q; quo_d = quo_q; dbit_d = dbit_q;
    px_d = px_q; py_d = py_q; sel_d = sel_q; res_d = res_q; rv_d = rv_q;
    if (rv_q && res_ready_i) rv_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (item_valid_i && item_ready_o) begin
          it_d = item_i;
          acc_d = 1'b0;
          raddr_d = slot(oldest_q, count_q - CW'(1));
          if (item_i.cmd == tsi_pkg::CmdPush) st_d = S_RDL;
          else if (count_q == '0) st_d = S_OUT;
          else st_d = S_RDL2;
        end
      end
      S_RDL: st_d = S_PUSH;
      S_PUSH: begin
        if (we) begin
          acc_d = 1'b1;
          if (!started_q) begin
            render_d = {it_q.point_tick, 16'd0};
            started_d = 1'b1;
          end
          if (count_q >= CW'(DEPTH)) begin
            oldest_d = slot(oldest_q, CW'(1));
          end else begin
            count_d = count_q + CW'(1);
          end
          if (((count_q >= CW'(DEPTH)) ? count_q : count_q + CW'(1)) > cap) begin
            oldest_d = slot(oldest_q, ((count_q >= CW'(DEPTH)) ? count_q : count_q + CW'(1))
                            - cap + ((count_q >= CW'(DEPTH)) ? CW'(1) : CW'(0)));
            count_d = cap;
          end
        end
        st_d = S_RDF2;
      end
      S_RDF2: begin
        raddr_d = oldest_q;
        k_d = '0;
        st_d = (count_q == '0) ? S_OUT : S_SRD;
      end
      S_RDL2: begin
        latest_d = trd_q;
        raddr_d = oldest_q;
        st_d = S_RDF;
      end
      S_RDF: st_d = S_ADV0;
      S_ADV0: begin
        first_d = trd_q;
        st_d = S_ADV;
      end
      S_ADV: begin
        latest_d = (latest_q > delay_ticks_i) ? latest_q - delay_ticks_i : 32'd0;
        sum_d = {1'b0, render_q} +
                (it_q.elapsed[31] ? 49'd0 : 49'(it_q.elapsed) * 49'(tick_rate_i));
        st_d = S_ADV2;
      end
      S_ADV2: begin
        if (sum_q < {1'b0, ((first_q > latest_q) ? first_q : latest_q), 16'd0})
          render_d = sum_q[47:0];
        else render_d = {((first_q > latest_q) ? first_q : latest_q), 16'd0};
        raddr_d = oldest_q;
        k_d = '0;
        st_d = S_SRD;
      end
      S_SRD: st_d = S_SCMP;  // read data lands for slot k
      S_SCMP: begin
        nt_d = trd_q; bx_d = xrd_q; by_d = yrd_q;
        if (k_q == '0) begin
          ax_d = xrd_q; ay_d = yrd_q;
          if (render_q <= {trd_q, 16'd0}) begin
            sel_d = 1'b1; st_d = S_MUL;
          end else if (count_q == CW'(1)) begin
            sel_d = 1'b1; st_d = S_MUL;
          end else begin
            pt_d = trd_q; k_d = CW'(1);
            raddr_d = slot(oldest_q, CW'(1)); st_d = S_SRD;
          end
        end else if (render_q <= {trd_q, 16'd0}) begin
          // the quotient fits 17 bits, so the top dividend bits start the remainder
          rem_d = {18'd0, num[47:17]}; quo_d = '0; dbit_d = 6'd16;
          st_d = S_DIV;
        end else if (k_q == count_q - CW'(1)) begin
          ax_d = xrd_q; ay_d = yrd_q; sel_d = 1'b1; st_d = S_MUL;
        end else begin
          pt_d = trd_q; ax_d = xrd_q; ay_d = yrd_q; k_d = k_q + CW'(1);
          raddr_d = slot(oldest_q, k_q + CW'(1)); st_d = S_SRD;
        end
      end
      S_DIV: begin
        if (!trial[49]) begin
          rem_d = trial[48:0];
          quo_d = quo_q | (17'd1 << dbit_q[4:0]);
        end else begin
          rem_d = {rem_q[47:0], num[dbit_q]};
        end
        dbit_d = dbit_q - 6'd1;
        if (dbit_q == 6'd0) st_d = S_XWT;
      end
      S_XWT: begin
        if (span == 32'd0) quo_d = 17'd0;
        else if (quo_q > 17'd65536) quo_d = 17'd65536;
        sel_d = 1'b0;
        st_d = S_MUL;
      end
      S_MUL: begin
        if (sel_q) begin
          px_d = 50'(signed'(ax_q)) <<< 16;
          py_d = 50'(signed'(ay_q)) <<< 16;
        end else begin
          px_d = (50'(signed'(bx_q)) - 50'(signed'(ax_q))) * signed'({33'd0, quo_q});
          py_d = (50'(signed'(by_q)) - 50'(signed'(ay_q))) * signed'({33'd0, quo_q});
        end
        st_d = S_SUM;
      end
      S_SUM: begin
        if (!sel_q) begin
          px_d = px_q + (50'(signed'(ax_q)) <<< 16);
          py_d = py_q + (50'(signed'(ay_q)) <<< 16);
        end
        st_d = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!rv_d) begin
          res_d.valid_res = (count_q != '0);
          res_d.out_x = (count_q != '0) ? px_q[47:0] : 48'd0;
          res_d.out_y = (count_q != '0) ? py_q[47:0] : 48'd0;
          res_d.push_accepted = acc_q;
          res_d.point_count = 7'(count_q);
          rv_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; oldest_q <= '0; count_q <= '0; render_q <= '0;
      started_q <= 1'b0; rv_q <= 1'b0; acc_q <= 1'b0; raddr_q <= '0;
    end else begin
      st_q <= st_d; oldest_q <= oldest_d; count_q <= count_d; render_q <= render_d;
      started_q <= started_d; rv_q <= rv_d; acc_q <= acc_d; raddr_q <= raddr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; first_q <= first_d; latest_q <= latest_d; sum_q <= sum_d;
    k_q <= k_d; pt_q <= pt_d; nt_q <= nt_d; ax_q <= ax_d; ay_q <= ay_d;
    bx_q <= bx_d; by_q <= by_d; rem_q <= rem_d; quo_q <= quo_d;
    dbit_q <= dbit_d; px_q <= px_d; py_q <= py_d; sel_q <= sel_d; res_q <= res_d;
  end

endmodule

>>> verif/tsi_checker.sv
// Checker for the timestamped sample interpolator: predicts each result
// from the accepted input and config items and compares. Depends on tsi_pkg.
`timescale 1ns / 1ps
module tsi_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               cmd_i,
  input  logic [31:0]        point_tick_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] elapsed_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               valid_res_i,
  input  logic signed [47:0] out_x_i,
  input  logic signed [47:0] out_y_i,
  input  logic               push_accepted_i,
  input  logic [6:0]         point_count_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned ExpDepth = 64;

  logic [31:0] ring_tick [DEPTH];
  logic [31:0] ring_x    [DEPTH];
  logic [31:0] ring_y    [DEPTH];
  int unsigned head;
  int unsigned fill;
  logic [47:0] play_tick;
  bit          primed;
  logic [31:0] lag_ticks;
  logic [6:0]  cap_reg;
  logic [9:0]  rate_reg;

  // expected results in order, written at input accept, read at output accept
  tsi_pkg::result_t exp_mem [ExpDepth];
  int unsigned      exp_wr;
  int unsigned      exp_rd;

  function automatic int unsigned slot(int unsigned k);
    return (head + k) % DEPTH;
  endfunction

  function automatic logic signed [47:0] mix(logic signed [31:0] a, logic signed [31:0] b,
                                             longint unsigned w);
    longint signed r;
    r = longint'(a) * 65536 + (longint'(b) - longint'(a)) * longint'(w);
    return r[47:0];
  endfunction

  task automatic predict_position(input tsi_pkg::item_t it);
    tsi_pkg::result_t r;
    int unsigned cap, s0, sp, sn;
    longint unsigned first_t, last_t, delayed, target, inc, sum, pt, nt, span, w;
    bit found;
    r = '0;
    cap = cap_reg < 2 ? 2 : (cap_reg > DEPTH ? DEPTH : cap_reg);
    if (it.cmd == tsi_pkg::CmdPush) begin
      if (fill == 0 || it.point_tick > ring_tick[slot(fill - 1)]) begin
        if (fill >= DEPTH) begin
          head = (head + 1) % DEPTH;
          fill--;
        end
        ring_tick[slot(fill)] = it.point_tick;
        ring_x[slot(fill)] = it.pos_x;
        ring_y[slot(fill)] = it.pos_y;
        fill++;
        if (!primed) begin
          play_tick = {it.point_tick, 16'h0};
          primed = 1;
        end
        while (fill > cap) begin
          head = (head + 1) % DEPTH;
          fill--;
        end
        r.push_accepted = 1;
      end
    end else if (fill != 0) begin
      first_t = ring_tick[slot(0)];
      last_t = ring_tick[slot(fill - 1)];
      delayed = last_t > lag_ticks ? last_t - lag_ticks : 0;
      target = (first_t > delayed ? first_t : delayed) << 16;
      inc = $signed(it.elapsed) > 0 ? longint'(it.elapsed) * rate_reg : 0;
      sum = longint'(play_tick) + inc;
      play_tick = sum < target ? sum[47:0] : target[47:0];
    end
    if (fill != 0) begin
      r.valid_res = 1;
      s0 = slot(0);
      found = 0;
      if (longint'(play_tick) <= (longint'(ring_tick[s0]) << 16)) begin
        r.out_x = mix(ring_x[s0], ring_x[s0], 0);
        r.out_y = mix(ring_y[s0], ring_y[s0], 0);
        found = 1;
      end
      for (int unsigned k = 1; k < fill && !found; k++) begin
        sp = slot(k - 1);
        sn = slot(k);
        pt = ring_tick[sp];
        nt = ring_tick[sn];
        if (longint'(play_tick) > (nt << 16)) continue;
        span = nt > pt ? nt - pt : 0;
        w = span != 0 ? (longint'(play_tick) - (pt << 16)) / span : 0;
        if (w > 65536) w = 65536;
        r.out_x = mix(ring_x[sp], ring_x[sn], w);
        r.out_y = mix(ring_y[sp], ring_y[sn], w);
        found = 1;
      end
      if (!found) begin
        sn = slot(fill - 1);
        r.out_x = mix(ring_x[sn], ring_x[sn], 0);
        r.out_y = mix(ring_y[sn], ring_y[sn], 0);
      end
    end
    r.point_count = fill[6:0];
    exp_mem[exp_wr % ExpDepth] = r;
    exp_wr++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tsi_pkg::result_t want;
    tsi_pkg::item_t it;
    if (!rst_ni) begin
      head = 0;
      fill = 0;
      play_tick = '0;
      primed = 0;
      lag_ticks = tsi_pkg::DelayReset;
      cap_reg = tsi_pkg::CapacityReset;
      rate_reg = tsi_pkg::TickRateReset;
      exp_wr = 0;
      exp_rd = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          tsi_pkg::RegDelay:    lag_ticks = cfg_data_i;
          tsi_pkg::RegCapacity: cap_reg = cfg_data_i[6:0];
          tsi_pkg::RegTickRate: rate_reg = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (exp_wr == exp_rd) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          want = exp_mem[exp_rd % ExpDepth];
          exp_rd++;
          if (want.valid_res !== valid_res_i || want.out_x !== out_x_i ||
              want.out_y !== out_y_i || want.push_accepted !== push_accepted_i ||
              want.point_count !== point_count_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch: exp v=%0b x=%0d y=%0d acc=%0b n=%0d",
                        " got v=%0b x=%0d y=%0d acc=%0b n=%0d"},
                       want.valid_res, want.out_x, want.out_y, want.push_accepted,
                       want.point_count, valid_res_i, out_x_i, out_y_i, push_accepted_i,
                       point_count_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        it = '{cmd_i, point_tick_i, pos_x_i, pos_y_i, elapsed_i};
        predict_position(it);
      end
    end
    pending_o = int'(exp_wr - exp_rd);
  end
endmodule

>>> verif/tb_timestamped_sample_interpolator.sv
// Testbench top for the timestamped sample interpolator: clock, reset,
// stimulus and verdict. Depends on tsi_pkg, tsi_checker and the RTL.
`timescale 1ns / 1ps
module tb_timestamped_sample_interpolator;

  localparam int StallLimit = 20000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               cmd_i;
  logic [31:0]        point_tick_i;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic signed [31:0] elapsed_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               valid_res_o;
  logic signed [47:0] out_x_o;
  logic signed [47:0] out_y_o;
  logic               push_accepted_o;
  logic [6:0]         point_count_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  int                 fail_count;
  int                 pending;
  int                 quiet_cycles;
  logic [31:0]        newest_tick;
  bit                 stall_mode;

  timestamped_sample_interpolator u_dut (.*);

  tsi_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .point_tick_i,
    .pos_x_i, .pos_y_i, .elapsed_i, .out_valid_i(out_valid_o), .out_ready_i,
    .valid_res_i(valid_res_o), .out_x_i(out_x_o), .out_y_i(out_y_o),
    .push_accepted_i(push_accepted_o), .point_count_i(point_count_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: alternate between long free runs and random stalls
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_ready_i <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // watchdog: no handshake of any kind for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else if (quiet_cycles + 1 >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // drive at the falling edge; back-to-back calls drop and raise valid in one step
  task automatic send_item(input logic c, input logic [31:0] t, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] e);
    in_valid_i = 1;
    cmd_i = c;
    point_tick_i = t;
    pos_x_i = x;
    pos_y_i = y;
    elapsed_i = e;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 0;
    if (c == tsi_pkg::CmdPush && (t > newest_tick)) newest_tick = t;
  endtask

  task automatic push_point(input logic [31:0] t);
    send_item(tsi_pkg::CmdPush, t, $urandom, $urandom, $urandom);
  endtask

  task automatic advance(input logic [31:0] e);
    send_item(tsi_pkg::CmdAdvance, $urandom, $urandom, $urandom, e);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    cfg_valid_i = 1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic random_phase(input int n);
    logic [31:0] step;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 30)) @(negedge clk_i);
      case ($urandom_range(0, 9))
        0: push_point($urandom);
        1, 2, 3, 4: begin
          step = $urandom_range(1, 6);
          push_point(newest_tick > 32'hFFFF_FFF0 ? $urandom : newest_tick + step);
        end
        5: advance($urandom);
        default: advance($urandom_range(0, 32'h0002_0000));
      endcase
    end
  endtask

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    cmd_i = tsi_pkg::CmdPush;
    point_tick_i = 0;
    pos_x_i = 0;
    pos_y_i = 0;
    elapsed_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = tsi_pkg::RegDelay;
    cfg_data_i = 0;
    out_ready_i = 1;
    stall_mode = 0;
    quiet_cycles = 0;
    newest_tick = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: empty buffer, extremes, equal and older ticks, capacity drop
    advance(32'h0001_0000);
    send_item(tsi_pkg::CmdPush, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(tsi_pkg::CmdPush, 32'd0, 32'h1, 32'h1, 32'h0);
    send_item(tsi_pkg::CmdPush, 32'd10, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    advance(32'h8000_0000);
    advance(32'h0000_4000);
    advance(32'h7FFF_FFFF);
    send_item(tsi_pkg::CmdPush, 32'd5, 32'h0, 32'h0, 32'h0);
    send_item(tsi_pkg::CmdPush, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1234);
    advance(32'h0000_0001);
    write_reg(tsi_pkg::RegCapacity, 7'd2);
    write_reg(tsi_pkg::RegDelay, 32'd0);
    write_reg(tsi_pkg::RegTickRate, 10'd0);
    advance(32'h0010_0000);
    write_reg(tsi_pkg::RegTickRate, 10'd1000);
    advance(32'h0000_0100);

    random_phase(300);
    write_reg(tsi_pkg::RegCapacity, 7'd64);
    write_reg(tsi_pkg::RegDelay, 32'hFFFF_FFFF);
    write_reg(tsi_pkg::RegTickRate, 10'd1);
    random_phase(250);
    write_reg(tsi_pkg::RegCapacity, 7'd127);
    write_reg(tsi_pkg::RegDelay, 32'd2);
    write_reg(tsi_pkg::RegTickRate, 10'd1023);
    random_phase(250);
    write_reg(tsi_pkg::RegCapacity, 7'd0);
    write_reg(tsi_pkg::RegDelay, 32'd5);
    write_reg(tsi_pkg::RegTickRate, 10'd30);
    random_phase(200);

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
